@@ rtl/abe_pkg.sv @@
// ----------------------------------------------------------------------------
// abe_pkg: shared types and constants of the audio bucket envelope
// payload structs, sequencer states, arithmetic unit commands, register indexes
// ----------------------------------------------------------------------------
package abe_pkg;

	// upper limits applied to the bucket registers
	localparam int unsigned MAX_SEGMENTS      = 4096;
	localparam int unsigned MAX_BUCKET_FRAMES = 65535;

	// datapath widths
	localparam int SUM_W     = 46;  // sum of squares
	localparam int SQ_W      = 32;  // one square
	localparam int DIVISOR_W = 17;  // frame count, 65536 on wrap
	localparam int ROOT_IN_W = 32;  // mean square fed to the root
	localparam int RMS_W     = 16;
	localparam int REM_W     = 18;  // partial remainder of divide and root
	localparam int STEP_W    = 6;

	// iteration counts of the shared unit
	localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_IN_W / 2);

	// configuration register indexes
	localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd0;
	localparam logic [1:0] CFG_BUCKET_FRAMES = 2'd1;
	localparam logic [1:0] CFG_BUCKET_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		FMT_U8,
		FMT_S8,
		FMT_U16,
		FMT_S16,
		FMT_U32,
		FMT_S32,
		FMT_F32,
		FMT_UNKNOWN
	} sample_fmt_t;

	typedef struct packed {
		logic [31:0] sample_word;
		logic        window_start;
	} frame_t;

	typedef struct packed {
		logic [11:0]        bucket_index;
		logic signed [15:0] min_level;
		logic signed [15:0] max_level;
		logic [15:0]        rms_level;
		logic               last_bucket;
	} bucket_t;

	typedef enum logic [2:0] {
		ARITH_IDLE,
		ARITH_LOAD,
		ARITH_DIV,
		ARITH_ROOT_INIT,
		ARITH_ROOT
	} arith_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_LOAD,
		ST_DIV,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/abe_arith.sv @@
// ----------------------------------------------------------------------------
// abe_arith: shared divide and square root unit
// one subtractor runs a restoring divide, then a digit-by-digit square root
// ----------------------------------------------------------------------------
module abe_arith
	import abe_pkg::*;
(
	input  logic                 clk,
	input  arith_op_t            op,
	input  logic [SUM_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [RMS_W-1:0]     root
);

	localparam int SUB_W = REM_W + 2;

	logic [SUM_W-1:0]     work_q;     // dividend out at top, quotient in at bottom
	logic [DIVISOR_W-1:0] divisor_q;
	logic [REM_W-1:0]     rem_q;
	logic [RMS_W-1:0]     root_q;

	logic [SUB_W-1:0] sub_a;
	logic [SUB_W-1:0] sub_b;
	logic [SUB_W:0]   diff;
	logic             borrow;

	// operand selection for the shared subtractor
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (op)
			ARITH_DIV: begin
				sub_a = SUB_W'({rem_q, work_q[SUM_W-1]});
				sub_b = SUB_W'(divisor_q);
			end
			ARITH_ROOT: begin
				sub_a = {rem_q, work_q[ROOT_IN_W-1 -: 2]};
				sub_b = SUB_W'({root_q, 2'b01});
			end
			default: begin
			end
		endcase
		diff   = {1'b0, sub_a} - {1'b0, sub_b};
		borrow = diff[SUB_W];
	end

	// one quotient or root bit per step
	always_ff @(posedge clk) begin
		case (op)
			ARITH_LOAD: begin
				work_q    <= dividend;
				divisor_q <= divisor;
				rem_q     <= '0;
			end
			ARITH_DIV: begin
				rem_q  <= borrow ? sub_a[REM_W-1:0] : diff[REM_W-1:0];
				work_q <= {work_q[SUM_W-2:0], ~borrow};
			end
			ARITH_ROOT_INIT: begin
				rem_q  <= '0;
				root_q <= '0;
			end
			ARITH_ROOT: begin
				rem_q  <= borrow ? sub_a[REM_W-1:0] : diff[REM_W-1:0];
				root_q <= {root_q[RMS_W-2:0], ~borrow};
				work_q <= {work_q[SUM_W-3:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	assign root = root_q;

endmodule

@@ rtl/audio_bucket_envelope.sv @@
// ----------------------------------------------------------------------------
// audio_bucket_envelope: min / max / rms envelope of an audio sample stream
// normalizes raw samples to q1.15 and reports one envelope per bucket
// ----------------------------------------------------------------------------
// usage
//   frame channel: one raw sample word per request, with window_start to
//   restart the bucket index and accumulators before that sample
//   bucket channel: one request per closed bucket with index, min, max, rms
//   cfg channel: register writes, always ready; the user must write only
//   while the block is idle, which the block itself leaves unenforced
//   samples: one that does not close a bucket is accepted, squared and
//   accumulated; one that closes a bucket adds load, 46 divide steps,
//   root setup and 16 root steps on the shared subtractor, plus emit;
//   one ignored after the window is finished is accepted and dropped;
//   frame_stall is high while a sample is being worked on
// reset
//   format s16, one frame per bucket, one bucket per window, empty bucket
// receiver stall
//   a finished bucket sits in the output register; the next samples are
//   taken meanwhile, and a further bucket waits in the emit step until free
// ----------------------------------------------------------------------------
module audio_bucket_envelope
	import abe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// sample requests
	input  logic        frame_valid,
	output logic        frame_stall,
	input  frame_t      frame,
	// bucket results
	output logic        bucket_valid,
	input  logic        bucket_stall,
	output bucket_t     bucket,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	state_t state_q;
	state_t state_next;

	sample_fmt_t fmt_q;
	logic [15:0] frames_cfg_q;
	logic [12:0] count_cfg_q;
	logic [15:0] frames_eff;
	logic [12:0] count_eff;

	logic [15:0]        fib_q;
	logic [12:0]        cur_q;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic [SUM_W-1:0]   sum_q;
	logic [STEP_W-1:0]  cnt_q;

	logic signed [15:0] sample_s1;
	logic [SQ_W-1:0]    sq_s2;
	logic signed [31:0] prod;

	logic             accept;
	logic [12:0]      cur_start;
	logic             ignore;
	logic             close;
	logic             out_free;
	logic             emit;
	arith_op_t        arith_op;
	logic [DIVISOR_W-1:0] divisor;
	logic [RMS_W-1:0] root;
	logic signed [15:0] norm;

	// float32 to q1.15, truncated toward zero, saturated beyond full scale
	function automatic logic signed [15:0] float_to_q15(input logic [31:0] w);
		logic [7:0]  e;
		logic [22:0] man;
		logic [23:0] m;
		logic [4:0]  sh;
		logic [15:0] mag;
		logic signed [15:0] r;
		e   = w[30:23];
		man = w[22:0];
		m   = {1'b1, man};
		sh  = 5'(8'd135 - e);
		mag = 16'(m >> sh);
		if (e == 8'hFF && man != '0) begin
			r = '0;
		end else if (e >= 8'd127) begin
			r = w[31] ? 16'sh8000 : 16'sh7FFF;
		end else if (e <= 8'd111) begin
			r = '0;
		end else begin
			r = w[31] ? -signed'(mag) : signed'(mag);
		end
		return r;
	endfunction

	// raw word to q1.15 in the configured format
	always_comb begin
		case (fmt_q)
			FMT_U8:  norm = {~frame.sample_word[7], frame.sample_word[6:0], 8'h00};
			FMT_S8:  norm = {frame.sample_word[7:0], 8'h00};
			FMT_U16: norm = {~frame.sample_word[15], frame.sample_word[14:0]};
			FMT_S16: norm = frame.sample_word[15:0];
			FMT_U32: norm = {~frame.sample_word[31], frame.sample_word[30:16]};
			FMT_S32: norm = frame.sample_word[31:16];
			FMT_F32: norm = float_to_q15(frame.sample_word);
			default: norm = '0;
		endcase
	end

	// effective bucket size and count
	always_comb begin
		if (frames_cfg_q == '0) begin
			frames_eff = 16'd1;
		end else if (32'(frames_cfg_q) > MAX_BUCKET_FRAMES) begin
			frames_eff = 16'(MAX_BUCKET_FRAMES);
		end else begin
			frames_eff = frames_cfg_q;
		end
		if (count_cfg_q == '0) begin
			count_eff = 13'd1;
		end else if (32'(count_cfg_q) > MAX_SEGMENTS) begin
			count_eff = 13'(MAX_SEGMENTS);
		end else begin
			count_eff = count_cfg_q;
		end
	end

	// request and window decisions
	assign accept    = frame_valid && !frame_stall;
	assign cur_start = frame.window_start ? '0 : cur_q;
	assign ignore    = cur_start >= count_eff;
	assign close     = (fib_q == '0) || (fib_q >= frames_eff);
	assign out_free  = !bucket_valid || !bucket_stall;
	assign divisor   = (fib_q == '0) ? {1'b1, 16'h0000} : {1'b0, fib_q};
	assign prod      = sample_s1 * sample_s1;
	assign cfg_ready = 1'b1;

	// sequencer next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:      if (accept && !ignore) state_next = ST_SQUARE;
			ST_SQUARE:    state_next = ST_ACCUM;
			ST_ACCUM:     state_next = close ? ST_LOAD : ST_IDLE;
			ST_LOAD:      state_next = ST_DIV;
			ST_DIV:       if (cnt_q == '0) state_next = ST_ROOT_INIT;
			ST_ROOT_INIT: state_next = ST_ROOT;
			ST_ROOT:      if (cnt_q == '0) state_next = ST_EMIT;
			ST_EMIT:      if (out_free) state_next = ST_IDLE;
			default:      state_next = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		frame_stall = 1'b1;
		arith_op    = ARITH_IDLE;
		emit        = 1'b0;
		case (state_q)
			ST_IDLE:      frame_stall = 1'b0;
			ST_LOAD:      arith_op = ARITH_LOAD;
			ST_DIV:       arith_op = ARITH_DIV;
			ST_ROOT_INIT: arith_op = ARITH_ROOT_INIT;
			ST_ROOT:      arith_op = ARITH_ROOT;
			ST_EMIT:      emit = out_free;
			default: begin
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_LOAD:      cnt_q <= DIV_STEPS - STEP_W'(1);
				ST_ROOT_INIT: cnt_q <= ROOT_STEPS - STEP_W'(1);
				ST_DIV,
				ST_ROOT:      cnt_q <= cnt_q - STEP_W'(1);
				default: begin
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_S16;
			frames_cfg_q <= 16'd1;
			count_cfg_q  <= 13'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_FORMAT: fmt_q <= sample_fmt_t'(cfg_data[2:0]);
				CFG_BUCKET_FRAMES: frames_cfg_q <= cfg_data;
				CFG_BUCKET_COUNT:  count_cfg_q <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// sample and square pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= norm;
		end
		if (state_q == ST_SQUARE) begin
			sq_s2 <= SQ_W'(unsigned'(prod));
		end
	end

	// bucket accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fib_q <= '0;
			cur_q <= '0;
			min_q <= 16'sh7FFF;
			max_q <= 16'sh8000;
			sum_q <= '0;
		end else begin
			if (accept && frame.window_start) begin
				fib_q <= '0;
				cur_q <= '0;
				min_q <= 16'sh7FFF;
				max_q <= 16'sh8000;
				sum_q <= '0;
			end
			if (state_q == ST_SQUARE) begin
				if (sample_s1 < min_q) min_q <= sample_s1;
				if (sample_s1 > max_q) max_q <= sample_s1;
				fib_q <= fib_q + 16'd1;
			end
			if (state_q == ST_ACCUM) begin
				sum_q <= sum_q + {{(SUM_W-SQ_W){1'b0}}, sq_s2};
			end
			if (emit) begin
				fib_q <= '0;
				cur_q <= cur_q + 13'd1;
				min_q <= 16'sh7FFF;
				max_q <= 16'sh8000;
				sum_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_valid <= 1'b0;
		end else if (emit) begin
			bucket_valid <= 1'b1;
		end else if (!bucket_stall) begin
			bucket_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bucket.bucket_index <= cur_q[11:0];
			bucket.min_level    <= min_q;
			bucket.max_level    <= max_q;
			bucket.rms_level    <= root;
			bucket.last_bucket  <= (cur_q + 13'd1) == count_eff;
		end
	end

	abe_arith u_arith (
		.clk      (clk),
		.op       (arith_op),
		.dividend (sum_q),
		.divisor  (divisor),
		.root     (root)
	);

	// checks
	a_new_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid && !$past(bucket_valid) |-> $past(state_q) == ST_EMIT)
		else $error("bucket result appeared outside the emit step");

	a_div_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q != '0 |=>
		state_q == ST_DIV && cnt_q == $past(cnt_q) - STEP_W'(1))
		else $error("divide step counter out of sequence");

	a_bucket_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) <= MAX_SEGMENTS)
		else $error("bucket index beyond window limit");

	a_rms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid |-> bucket.rms_level <= 16'd32768)
		else $error("rms above full scale");

	a_emit_clears_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> fib_q == '0 && sum_q == '0)
		else $error("accumulators not cleared after bucket close");

endmodule
